/* sv/hidm_pkg.sv */
// shared types and constants for the handle to identifier map table
// no dependencies; used by hidm_slot_mem, handle_to_id_map_table_top and the testbench
package hidm_pkg;

	localparam logic [63:0] STREAM_BASE = 64'h2000_0000_0000_0000;
	localparam int unsigned STREAM_COUNT = 3;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_SEARCH = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HREAD,
		ST_HWAIT,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  handle;
		logic [63:0] ident;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [7:0]  result_handle;
		logic [63:0] result_ident;
	} rsp_t;

	// one read and one write port of the slot store
	typedef struct packed {
		logic        rd_en;
		logic [7:0]  rd_addr;
		logic        wr_en;
		logic [7:0]  wr_addr;
		logic [63:0] wr_data;
	} mem_req_t;

endpackage

/* sv/hidm_slot_mem.sv */
// slot store: one write and one registered read port, with per-slot written flags
// an unwritten slot reads as its reset value; depends on hidm_pkg
module hidm_slot_mem
	import hidm_pkg::*;
#(
	parameter int unsigned DEPTH  = 32,
	parameter int unsigned ADDR_W = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_req_t    mreq,
	output logic [63:0] entry
);

	logic [63:0]       mem [DEPTH];
	logic [DEPTH-1:0]  written_q;
	logic [63:0]       rdata_s1;
	logic              rvld_s1;
	logic [ADDR_W-1:0] raddr_s1;
	logic [ADDR_W-1:0] wa;
	logic [ADDR_W-1:0] ra;

	assign wa = mreq.wr_addr[ADDR_W-1:0];
	assign ra = mreq.rd_addr[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[wa] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			rdata_s1 <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvld_s1   <= 1'b0;
			raddr_s1  <= '0;
		end else begin
			if (mreq.wr_en) begin
				written_q[wa] <= 1'b1;
			end
			if (mreq.rd_en) begin
				rvld_s1  <= written_q[ra];
				raddr_s1 <= ra;
			end
		end
	end

	// reset content: stream ids in the low slots, zero elsewhere
	always_comb begin
		if (rvld_s1) begin
			entry = rdata_s1;
		end else if (32'(raddr_s1) < STREAM_COUNT) begin
			entry = STREAM_BASE | 64'(raddr_s1);
		end else begin
			entry = '0;
		end
	end

endmodule

/* sv/handle_to_id_map_table_top.sv */
// top level of the handle to identifier map table: request sequencer and result register
// depends on hidm_pkg and hidm_slot_mem
//
// One request is worked at a time and gives one result word. Lookup and remove read the
// addressed slot through the registered read port of the slot store; add and reverse
// search scan the slot store one entry per cycle through its single read port, up to the
// matching slot or the last one. Out-of-range handles skip the read and go straight to the
// result. req_stall is high while a request is in work or its result is waiting for
// a full output register. After reset, slots 0 to 2 hold the standard-stream ids and
// the rest read as 0; no clearing pass is needed. cfg_ready is always high, and the
// empty marker is compared live, so changing it does not rewrite the table.
module handle_to_id_map_table_top
	import hidm_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data
);

	localparam int unsigned ADDR_W = $clog2(TABLE_SIZE);
	localparam logic [8:0] LIMIT = 9'(TABLE_SIZE);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_SIZE - 1);

	state_t            state_q, state_d;
	req_t              req_q;
	rsp_t              res_q, res_d;
	rsp_t              out_q;
	logic              out_valid_q;
	logic [63:0]       empty_q;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic              rpend_s1;
	logic [ADDR_W-1:0] raddr_s1;
	mem_req_t          mreq;
	logic [63:0]       entry;
	logic [63:0]       target;
	logic              out_load;

	hidm_slot_mem #(
		.DEPTH (TABLE_SIZE),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.mreq  (mreq),
		.entry (entry)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign target    = (req_q.kind == KIND_ADD) ? empty_q : req_q.ident;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		addr_d  = addr_q;
		res_d   = res_q;
		mreq    = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req.kind)
						KIND_ADD, KIND_SEARCH: begin
							addr_d  = '0;
							state_d = ST_SCAN;
						end
						default: begin
							if ({1'b0, req.handle} < LIMIT) begin
								state_d = ST_HREAD;
							end else begin
								res_d   = '{ok: 1'b0, result_handle: 8'd0, result_ident: empty_q};
								state_d = ST_DONE;
							end
						end
					endcase
				end
			end
			ST_HREAD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = req_q.handle;
				state_d      = ST_HWAIT;
			end
			ST_HWAIT: begin
				res_d = '{ok: 1'b1, result_handle: 8'd0, result_ident: entry};
				if (req_q.kind == KIND_REMOVE) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = req_q.handle;
					mreq.wr_data = empty_q;
				end
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				// read of addr_q goes out while the previous slot is compared
				if (rpend_s1 && entry == target) begin
					res_d = '{ok: 1'b1, result_handle: 8'(raddr_s1), result_ident: 64'd0};
					if (req_q.kind == KIND_ADD) begin
						mreq.wr_en   = 1'b1;
						mreq.wr_addr = 8'(raddr_s1);
						mreq.wr_data = req_q.ident;
					end
					state_d = ST_DONE;
				end else if (rpend_s1 && raddr_s1 == LAST) begin
					res_d   = '0;
					state_d = ST_DONE;
				end else begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = 8'(addr_q);
					addr_d       = addr_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			empty_q     <= '0;
			rpend_s1    <= 1'b0;
			addr_q      <= '0;
		end else begin
			state_q  <= state_d;
			addr_q   <= addr_d;
			rpend_s1 <= mreq.rd_en;
			if (cfg_valid && cfg_ready) begin
				empty_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q    <= res_d;
		raddr_s1 <= mreq.rd_addr[ADDR_W-1:0];
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

endmodule

/* sim/testbench.sv */
// testbench for handle_to_id_map_table_top: directed table of requests, then random phases
// that each set a new empty marker; results are checked against an in-bench copy of the table
// depends on hidm_pkg and the rtl of handle_to_id_map_table_top
module testbench;
	import hidm_pkg::*;

	localparam int unsigned SLOTS = 32;
	localparam int unsigned PHASE_ITEMS = 250;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned HOLD_CYCLES = 200;

	typedef struct {
		bit          is_cfg;
		req_t        request;
		bit          typed;
		rsp_t        answer;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [63:0] cfg_data = '0;

	// in-bench copy of the slot store and the marker register
	logic [63:0] id_slots [SLOTS];
	logic [63:0] free_id;
	rsp_t        due_results [$];
	int unsigned errors = 0;
	int unsigned words_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          calm = 1'b0;
	bit          rx_hold = 1'b0;

	handle_to_id_map_table_top #(
		.TABLE_SIZE(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// applies one request to the table copy and returns the result word it gives
	function automatic rsp_t serve_request(input req_t r);
		rsp_t        o;
		logic [63:0] target;
		o = '0;
		if (r.kind == KIND_ADD || r.kind == KIND_SEARCH) begin
			target = (r.kind == KIND_ADD) ? free_id : r.ident;
			for (int i = 0; i < SLOTS; i++) begin
				if (!o.ok && id_slots[i] == target) begin
					if (r.kind == KIND_ADD)
						id_slots[i] = r.ident;
					o.ok = 1'b1;
					o.result_handle = 8'(i);
				end
			end
		end else if (r.handle < SLOTS) begin
			o.ok = 1'b1;
			o.result_ident = id_slots[r.handle];
			if (r.kind == KIND_REMOVE)
				id_slots[r.handle] = free_id;
		end else begin
			o.result_ident = free_id;
		end
		return o;
	endfunction

	function automatic dir_row_t dir_row(input bit is_cfg, input kind_t k, input logic [7:0] h,
			input logic [63:0] id, input bit typed, input logic ok, input logic [7:0] rh,
			input logic [63:0] rid);
		dir_row_t row;
		row.is_cfg = is_cfg;
		row.request.kind = k;
		row.request.handle = h;
		row.request.ident = id;
		row.typed = typed;
		row.answer.ok = ok;
		row.answer.result_handle = rh;
		row.answer.result_ident = rid;
		return row;
	endfunction

	// mode 0 leans on add, 1 is even, 2 leans on remove
	function automatic req_t random_request(input int unsigned mode);
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		case (mode)
			0: r.kind = pick < 60 ? KIND_ADD : pick < 70 ? KIND_REMOVE :
				pick < 85 ? KIND_LOOKUP : KIND_SEARCH;
			1: r.kind = pick < 25 ? KIND_ADD : pick < 50 ? KIND_REMOVE :
				pick < 75 ? KIND_LOOKUP : KIND_SEARCH;
			default: r.kind = pick < 15 ? KIND_ADD : pick < 65 ? KIND_REMOVE :
				pick < 80 ? KIND_LOOKUP : KIND_SEARCH;
		endcase
		if ($urandom_range(0, 9) == 0)
			r.handle = 8'($urandom_range(0, 255));
		else
			r.handle = 8'($urandom_range(0, SLOTS - 1));
		// copies of live entries make searches hit
		case ($urandom_range(0, 9))
			4, 5, 6: r.ident = id_slots[$urandom_range(0, SLOTS - 1)];
			7: r.ident = free_id;
			8: r.ident = 64'($urandom_range(0, 7));
			9: r.ident = ~free_id;
			default: r.ident = {$urandom, $urandom};
		endcase
		return r;
	endfunction

	task automatic send_request(input req_t r, input rsp_t want);
		while (!calm && $urandom_range(0, 99) < 8) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		due_results.push_back(want);
		words_sent++;
	endtask

	task automatic settle();
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
	endtask

	task automatic write_marker(input logic [63:0] value);
		req_valid <= 1'b0;
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		free_id = value;
	endtask

	always @(posedge clk) begin
		rsp_stall <= rx_hold || (!calm && $urandom_range(0, 99) < 8);
	end

	// long receiver hold-off while the sender keeps offering words
	initial begin
		wait (words_sent >= 1000);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected: %p", $time, rsp);
			end else begin
				want = due_results.pop_front();
				if (rsp.ok !== want.ok) begin
					errors++;
					$display("%0t: ok mismatch: expected %b, got %b", $time, want.ok, rsp.ok);
				end
				if (rsp.result_handle !== want.result_handle) begin
					errors++;
					$display("%0t: result_handle mismatch: expected %0d, got %0d", $time,
						want.result_handle, rsp.result_handle);
				end
				if (rsp.result_ident !== want.result_ident) begin
					errors++;
					$display("%0t: result_ident mismatch: expected %h, got %h", $time,
						want.result_ident, rsp.result_ident);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time, due_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t    rows [$];
		rsp_t        want;
		req_t        r;
		logic [63:0] mark;
		logic [63:0] s;
		s = STREAM_BASE;
		free_id = '0;
		for (int i = 0; i < SLOTS; i++)
			id_slots[i] = (i < STREAM_COUNT) ? (STREAM_BASE | 64'(i)) : 64'h0;

		rows.push_back(dir_row(0, KIND_LOOKUP, 8'd0, '0, 1, 1'b1, 8'd0, s));
		rows.push_back(dir_row(0, KIND_LOOKUP, 8'd31, '0, 1, 1'b1, 8'd0, '0));
		rows.push_back(dir_row(0, KIND_LOOKUP, 8'd32, '1, 1, 1'b0, 8'd0, '0));
		rows.push_back(dir_row(0, KIND_REMOVE, 8'd255, '0, 1, 1'b0, 8'd0, '0));
		rows.push_back(dir_row(0, KIND_SEARCH, 8'd0, s | 64'd2, 1, 1'b1, 8'd2, '0));
		// not found
		rows.push_back(dir_row(0, KIND_SEARCH, 8'd7, '1, 1, 1'b0, 8'd0, '0));
		// search for the marker finds the lowest free slot
		rows.push_back(dir_row(0, KIND_SEARCH, 8'd0, '0, 1, 1'b1, 8'd3, '0));
		rows.push_back(dir_row(0, KIND_ADD, 8'd0, '1, 1, 1'b1, 8'd3, '0));
		// adding the marker itself leaves the slot free
		rows.push_back(dir_row(0, KIND_ADD, 8'd255, '0, 1, 1'b1, 8'd4, '0));
		rows.push_back(dir_row(0, KIND_ADD, 8'd0, 64'h0123_4567_89ab_cdef, 1, 1'b1, 8'd4, '0));
		rows.push_back(dir_row(0, KIND_REMOVE, 8'd1, '0, 1, 1'b1, 8'd0, s | 64'd1));
		rows.push_back(dir_row(0, KIND_LOOKUP, 8'd1, '1, 1, 1'b1, 8'd0, '0));
		rows.push_back(dir_row(0, KIND_ADD, 8'd0, 64'h8000_0000_0000_0001, 1, 1'b1, 8'd1, '0));
		rows.push_back(dir_row(0, KIND_REMOVE, 8'd31, '0, 1, 1'b1, 8'd0, '0));
		rows.push_back(dir_row(0, KIND_SEARCH, 8'd0, 64'h8000_0000_0000_0001, 0, 0, 0, '0));
		// marker changes are judged live, slot 3 now counts as free
		rows.push_back(dir_row(1, KIND_ADD, 8'd0, '1, 0, 0, 0, '0));
		rows.push_back(dir_row(0, KIND_ADD, 8'd0, 64'h5555_5555_5555_5555, 1, 1'b1, 8'd3, '0));
		rows.push_back(dir_row(0, KIND_LOOKUP, 8'd200, '0, 1, 1'b0, 8'd0, '1));
		rows.push_back(dir_row(0, KIND_REMOVE, 8'd0, '0, 1, 1'b1, 8'd0, s));
		rows.push_back(dir_row(0, KIND_SEARCH, 8'd0, '1, 1, 1'b1, 8'd0, '0));
		// no slot holds this marker, so the table is full
		rows.push_back(dir_row(1, KIND_ADD, 8'd0, 64'hdead_beef_0000_0000, 0, 0, 0, '0));
		rows.push_back(dir_row(0, KIND_ADD, 8'd0, 64'haaaa_aaaa_aaaa_aaaa, 1, 1'b0, 8'd0, '0));
		rows.push_back(dir_row(0, KIND_REMOVE, 8'd255, '0, 1, 1'b0, 8'd0,
			64'hdead_beef_0000_0000));
		rows.push_back(dir_row(0, KIND_REMOVE, 8'd5, '0, 1, 1'b1, 8'd0, '0));
		rows.push_back(dir_row(0, KIND_ADD, 8'd0, 64'haaaa_aaaa_aaaa_aaaa, 1, 1'b1, 8'd5, '0));
		rows.push_back(dir_row(0, KIND_SEARCH, 8'd9, 64'haaaa_aaaa_aaaa_aaaa, 0, 0, 0, '0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[n]) begin
			if (rows[n].is_cfg) begin
				write_marker(rows[n].request.ident);
			end else begin
				want = serve_request(rows[n].request);
				if (rows[n].typed)
					want = rows[n].answer;
				send_request(rows[n].request, want);
			end
		end

		for (int p = 0; p < 7; p++) begin
			case (p)
				0, 5: mark = '0;
				1: mark = '1;
				3: mark = id_slots[$urandom_range(0, SLOTS - 1)];
				4: mark = 64'h8000_0000_0000_0000;
				default: mark = {$urandom, $urandom};
			endcase
			// each phase starts from an idle block, so the sender also waits out every result
			write_marker(mark);
			calm <= (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = random_request(p % 3);
				send_request(r, serve_request(r));
			end
		end

		req_valid <= 1'b0;
		settle();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
sv/hidm_pkg.sv
sv/hidm_slot_mem.sv
sv/handle_to_id_map_table_top.sv
sim/testbench.sv
